FILE: src/fccs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fccs_pkg: shared types, constants and functions of the fire cooling stencil
// Widths, reset values, the tap bundle and the cooling arithmetic.
// ----------------------------------------------------------------------------
package fccs_pkg;

    localparam int          ROW_WIDTH_DEF = 128;
    localparam int          HEAT_W        = 8;
    localparam int          DAMP_W        = 10;
    localparam int          SUM_W         = 10;
    localparam logic [HEAT_W-1:0] HOT_LIMIT   = 8'd96;
    localparam logic [DAMP_W-1:0] DAMPING_RST = 10'd6;

    // Partial sums formed from the window taps at accept time
    typedef struct packed {
        logic [SUM_W-1:0] base;     // upper row triple plus center
        logic [SUM_W-1:0] hot_add;  // center row triple plus newest pixel
        logic             hot;      // center above the hot limit
        logic             produce;  // window full, a result is due
    } t_taps;

    // Blend when hot, subtract the cooling offset, divide by four, clamp at zero
    function automatic logic [HEAT_W-1:0] cool_value(
        input logic [SUM_W-1:0]  base,
        input logic [SUM_W-1:0]  hot_add,
        input logic              hot,
        input logic [DAMP_W-1:0] damping
    );
        logic [SUM_W:0]   total;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] diff;
        total = {1'b0, base} + {1'b0, hot_add};
        sum   = hot ? total[SUM_W:1] : base;
        diff  = sum - damping;
        return (sum >= damping) ? diff[SUM_W-1:2] : '0;
    endfunction

endpackage
`default_nettype wire

FILE: src/fccs_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fccs_window: pixel delay line and frame position counter
// Shifts one heat byte per transaction and forms the two neighbor sums.
// ----------------------------------------------------------------------------
module fccs_window #(
    parameter int ROW_WIDTH = fccs_pkg::ROW_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [fccs_pkg::HEAT_W-1:0] i_heat_in,
    input  wire logic                        i_last_in,
    output fccs_pkg::t_taps                  o_taps
);

    localparam int WIN_DEPTH = 2 * ROW_WIDTH + 1;
    localparam int POS_W     = $clog2(3 * ROW_WIDTH + 1);
    localparam logic [POS_W-1:0] START_COUNT = POS_W'(3 * ROW_WIDTH);

    logic [fccs_pkg::HEAT_W-1:0] r_win [WIN_DEPTH];
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            n_pos;

    // Delay line: r_win[k] holds the pixel taken k+1 transactions ago
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win[0] <= i_heat_in;
            for (int k = 1; k < WIN_DEPTH; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (i_last_in) begin
            n_pos = '0;
        end else if (r_pos < START_COUNT) begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_comb begin
        o_taps.base    = {2'b00, r_win[2*ROW_WIDTH]}   + {2'b00, r_win[2*ROW_WIDTH-1]}
                       + {2'b00, r_win[2*ROW_WIDTH-2]} + {2'b00, r_win[ROW_WIDTH-1]};
        o_taps.hot_add = {2'b00, r_win[ROW_WIDTH]}     + {2'b00, r_win[ROW_WIDTH-1]}
                       + {2'b00, r_win[ROW_WIDTH-2]}   + {2'b00, i_heat_in};
        o_taps.hot     = r_win[ROW_WIDTH-1] > fccs_pkg::HOT_LIMIT;
        o_taps.produce = r_pos >= START_COUNT;
    end

endmodule
`default_nettype wire

FILE: src/fire_cellular_cooling_stencil.sv
`timescale 1ns / 1ps
`default_nettype none
// A result goes through stage 1 and the result register before it appears on o_valid.
// Throughput: one pixel per cycle when not stalled; the delay line and a two-register pipeline set it.
// The first 3*ROW_WIDTH pixels of a frame give no result; after that each pixel gives one.
// Reset (synchronous, active low) clears the position counter, the pipeline valids
// and sets damping to 6; the delay line is not cleared, it refills before use.
// ----------------------------------------------------------------------------
// fire_cellular_cooling_stencil: streaming fire cooling stencil
// Sums neighbors from a 2W+1 pixel delay line, blends hot pixels with the row
// below, subtracts the damping offset and divides by four.
// ----------------------------------------------------------------------------
module fire_cellular_cooling_stencil #(
    parameter int ROW_WIDTH = fccs_pkg::ROW_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_damping_we,
    input  wire logic [fccs_pkg::DAMP_W-1:0] i_damping,
    // input channel
    input  wire logic                        i_valid,
    output      logic                        o_stall,
    input  wire logic [fccs_pkg::HEAT_W-1:0] i_heat_in,
    input  wire logic                        i_last_in,
    // output channel
    output      logic                        o_valid,
    input  wire logic                        i_stall,
    output      logic [fccs_pkg::HEAT_W-1:0] o_heat_out,
    output      logic                        o_last_out
);

    logic [fccs_pkg::DAMP_W-1:0] r_damping;

    fccs_pkg::t_taps             w_taps;
    logic                        w_accept;
    logic                        w_adv;
    logic                        w_s1_free;

    // stage 1: partial sums of one transaction
    logic                        r_s1_valid;
    logic [fccs_pkg::SUM_W-1:0]  r_s1_base;
    logic [fccs_pkg::SUM_W-1:0]  r_s1_hot_add;
    logic                        r_s1_hot;
    logic                        r_s1_last;

    // result register
    logic                        r_out_valid;
    logic [fccs_pkg::HEAT_W-1:0] r_out_heat;
    logic                        r_out_last;

    // Output register moves when empty or taken; stage 1 frees up with it
    assign w_adv     = !r_out_valid || !i_stall;
    assign w_s1_free = !r_s1_valid || w_adv;
    assign o_stall   = !w_s1_free;
    assign w_accept  = i_valid && w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping <= fccs_pkg::DAMPING_RST;
        end else if (i_damping_we) begin
            r_damping <= i_damping;
        end
    end

    fccs_window #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_heat_in (i_heat_in),
        .i_last_in (i_last_in),
        .o_taps    (w_taps)
    );

    // Stage 1: valid only for transactions that produce a result; sums load on every accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_accept && w_taps.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_base    <= w_taps.base;
            r_s1_hot_add <= w_taps.hot_add;
            r_s1_hot     <= w_taps.hot;
            r_s1_last    <= i_last_in;
        end
    end

    // Result register: finish the cooling arithmetic on the way out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out_heat <= fccs_pkg::cool_value(r_s1_base, r_s1_hot_add, r_s1_hot,
                                               r_damping);
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_heat_out = r_out_heat;
    assign o_last_out = r_out_last;

`ifndef SYNTHESIS
    // Full pipeline with a stalled result must hold off the input side
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && r_s1_valid) |-> o_stall)
        else $error("input taken while pipeline full");

    // A producing transaction always lands in stage 1
    a_s1_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_taps.produce) |=> r_s1_valid)
        else $error("producing transaction lost");

    // Taken result with nothing behind it leaves the output empty
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_stall && !r_s1_valid) |=> !r_out_valid)
        else $error("result repeated");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fire cooling stencil
// Streams heat frames through the block: a table of short, cold and hot
// uniform frames first, then random segments that run the open frame on with
// changing damping and occasional frame ends. A behavioral copy of the stencil
// predicts every cooled pixel; each output transaction is compared against the
// oldest prediction. Both channels idle at random, and once the output side
// holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HEAT_W        = fccs_pkg::HEAT_W;
    localparam int DAMP_W        = fccs_pkg::DAMP_W;
    localparam int ROW_W         = fccs_pkg::ROW_WIDTH_DEF;
    localparam int TAPS          = 2 * ROW_W + 1;   // delay line depth
    localparam int FILL          = 3 * ROW_W;       // silent pixels at frame start
    localparam int RANDOM_PIXELS = 460;
    localparam int LIMIT         = 200000;          // watchdog, in clock cycles
    localparam int DRAIN_CYCLES  = 4;               // pipeline is two deep
    localparam int CALM_FROM     = 300;             // window with no idling
    localparam int CALM_TO       = 700;
    localparam int HOLD_AFTER    = 16;              // results before the long hold
    localparam int HOLD_CYCLES   = 400;
    localparam int NO_TYPED      = -1;              // row marker: use the predictor
    localparam int RANDOM_HEAT   = -1;              // row marker: random pixels
    localparam int KEEP_DAMPING  = -1;              // row marker: no register write

    // One cooled pixel as it leaves the block
    typedef struct {
        logic [HEAT_W-1:0] heat;
        logic              last;
    } t_cooled;

    // One row of the directed table: a run of pixels
    typedef struct packed {
        int damp;       // value to write first, or KEEP_DAMPING
        int heat;       // uniform pixel value, or RANDOM_HEAT
        int count;      // pixels in the run
        int last_end;   // mark the final pixel with last_in
        int typed;      // expected heat_out of every result, or NO_TYPED
    } t_frame_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_damping_we;
    logic [DAMP_W-1:0] i_damping;
    logic              i_valid;
    logic              o_stall;
    logic [HEAT_W-1:0] i_heat_in;
    logic              i_last_in;
    logic              o_valid;
    logic              i_stall;
    logic [HEAT_W-1:0] o_heat_out;
    logic              o_last_out;

    // Typed expectation that rides along with the payload it belongs to
    int                drv_typed;

    // Predictor state: delay line, frame position and the damping register
    logic [HEAT_W-1:0] heat_line [0:TAPS-1];
    int                frame_pos;
    logic [DAMP_W-1:0] damp_now;

    t_cooled           cooled_q[$];
    int                cyc;
    int                checked;
    int                errors;
    bit                hold_done;
    wire               calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    fire_cellular_cooling_stencil #(
        .ROW_WIDTH   (ROW_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_damping_we(i_damping_we),
        .i_damping   (i_damping),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_heat_in   (i_heat_in),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_heat_out  (o_heat_out),
        .o_last_out  (o_last_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: count cycles and bail out well past the slowest legal run
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Advance the stencil by one pixel. A result comes out only once the frame
    // has seen three full rows; the neighbors are plain linear offsets, so they
    // wrap across row ends. The center pixel sits ROW_W-1 taps deep.
    task automatic cool_pixel(input logic [HEAT_W-1:0] heat, input logic last,
                              output bit made, output logic [HEAT_W-1:0] val);
        int center;
        int sum;
        int k;
        made = 1'b0;
        val  = '0;
        if (frame_pos >= FILL) begin
            center = heat_line[ROW_W-1];
            sum = heat_line[2*ROW_W] + heat_line[2*ROW_W-1] + heat_line[2*ROW_W-2] + center;
            // hot center: blend in the row below, then halve
            if (center > fccs_pkg::HOT_LIMIT)
                sum = (sum + heat_line[ROW_W] + center + heat_line[ROW_W-2] + heat) >> 1;
            val  = (sum >= damp_now) ? HEAT_W'((sum - damp_now) >> 2) : '0;
            made = 1'b1;
        end
        for (k = TAPS - 1; k > 0; k--)
            heat_line[k] = heat_line[k-1];
        heat_line[0] = heat;
        // end of frame restarts the position; otherwise saturate at the fill
        if (last)
            frame_pos = 0;
        else if (frame_pos < FILL)
            frame_pos++;
    endtask

    // Track accepted pixels and check accepted results in one place, so the
    // push for an input always lands before the pop for an output on one edge.
    always @(posedge i_clk) begin
        bit                made;
        logic [HEAT_W-1:0] val;
        t_cooled           want;
        t_cooled           got;
        if (i_rst_n && i_valid && !o_stall) begin
            cool_pixel(i_heat_in, i_last_in, made, val);
            if (made) begin
                want.heat = (drv_typed != NO_TYPED) ? HEAT_W'(drv_typed) : val;
                want.last = i_last_in;
                cooled_q.push_back(want);
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got.heat = o_heat_out;
            got.last = o_last_out;
            if (cooled_q.size() == 0) begin
                $display("%0t: result with none expected, heat_out %0d last_out %0b",
                         $time, got.heat, got.last);
                errors++;
            end else begin
                want = cooled_q.pop_front();
                if (got.heat !== want.heat) begin
                    $display("%0t: heat_out mismatch, expected %0d, actual %0d",
                             $time, want.heat, got.heat);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last_out mismatch, expected %0b, actual %0b",
                             $time, want.last, got.last);
                    errors++;
                end
                checked <= checked + 1;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off while a frame is
    // producing, so the pipeline fills and the block has to stall its input.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && i_rst_n && checked >= HOLD_AFTER && cooled_q.size() != 0) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 25);
        end
    end

    // Bias pixels toward the hot threshold and the byte extremes
    function automatic logic [HEAT_W-1:0] pick_heat();
        case ($urandom_range(0, 9))
            0, 1, 2: return HEAT_W'($urandom_range(fccs_pkg::HOT_LIMIT - 2,
                                                   fccs_pkg::HOT_LIMIT + 3));
            3:       return '0;
            4:       return '1;
            default: return HEAT_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [DAMP_W-1:0] pick_damping();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DAMP_W'(1020);
            default: return DAMP_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Offer one pixel, idling first at random; hold the payload until accepted
    task automatic send_pixel(input logic [HEAT_W-1:0] heat, input logic last,
                              input int typed);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_heat_in <= heat;
        i_last_in <= last;
        drv_typed <= typed;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_frame(input int heat, input int count, input bit last_end,
                              input int typed);
        int i;
        for (i = 0; i < count; i++)
            send_pixel((heat == RANDOM_HEAT) ? pick_heat() : HEAT_W'(heat),
                       last_end && (i == count - 1), typed);
    endtask

    // Write damping only with the block idle: drain every result, then give
    // silent pixels still in the pipeline time to fall out.
    task automatic set_damping(input logic [DAMP_W-1:0] value);
        i_valid <= 1'b0;
        while (cooled_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_damping_we <= 1'b1;
        i_damping    <= value;
        @(posedge i_clk);
        i_damping_we <= 1'b0;
        damp_now = value;
    endtask

    // Directed runs. A short frame and a one-pixel frame lose their end mark.
    // Uniform runs give one value for every result:
    //   cold frame at reset damping, ending on the first producing pixel -> 0
    //   all 255, hot blend, damping 6                  -> (1020 - 6) / 4
    //   all 255 with damping 0, 1023 (sum below), 1020 -> 255, 0, 0
    // The last frame stays open so the random part runs on from it.
    t_frame_row frame_rows [0:6] = '{
        '{KEEP_DAMPING, RANDOM_HEAT, 10,        1, NO_TYPED},
        '{KEEP_DAMPING, RANDOM_HEAT, 1,         1, NO_TYPED},
        '{KEEP_DAMPING, 0,           FILL + 1,  1, 0},
        '{KEEP_DAMPING, 255,         FILL + 2,  0, 253},
        '{0,            255,         2,         0, 255},
        '{1023,         255,         2,         0, 0},
        '{1020,         255,         2,         0, 0}
    };

    initial begin
        int  r;
        int  sent;
        int  len;
        bit  last_end;
        // predictor matches the block after reset
        for (r = 0; r < TAPS; r++)
            heat_line[r] = '0;
        frame_pos = 0;
        damp_now  = fccs_pkg::DAMPING_RST;
        cyc       = 0;
        checked   = 0;
        errors    = 0;
        hold_done = 1'b0;

        i_rst_n      <= 1'b0;
        i_damping_we <= 1'b0;
        i_damping    <= '0;
        i_valid      <= 1'b0;
        i_heat_in    <= '0;
        i_last_in    <= 1'b0;
        drv_typed    <= NO_TYPED;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frame_rows[row]) begin
            if (frame_rows[row].damp != KEEP_DAMPING)
                set_damping(DAMP_W'(frame_rows[row].damp));
            send_frame(frame_rows[row].heat, frame_rows[row].count,
                       frame_rows[row].last_end != 0, frame_rows[row].typed);
        end

        // Random segments: run the open frame on with fresh damping now and
        // then; once the long hold is done, end the frame at random so later
        // segments refill from a fresh start.
        set_damping(DAMP_W'(6));
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 3) == 0)
                set_damping(pick_damping());
            len      = $urandom_range(1, 60);
            last_end = hold_done && ($urandom_range(0, 9) == 0);
            send_frame(RANDOM_HEAT, len, last_end, NO_TYPED);
            sent += len;
        end
        i_valid <= 1'b0;

        // drain, then let the pipeline settle before the verdict
        while (cooled_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
